[hw/rtl/axis_angle_vector_rotation_core_defines.svh]
// Assertion macros for the axis-angle rotation core.
// Used by axis_angle_vector_rotation_core; expects clk and rst_n in scope.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AAVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AAVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AAVR_ASSERT(lbl, prop, msg)
`define AAVR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/aavr_pkg.sv]
// Shared constants, types and width helpers for the axis-angle rotation core.
// No dependencies.
`default_nettype none
package aavr_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int AXIS_W         = 16;
  localparam int VEC_W          = 18;
  localparam int ANG_W          = 16;
  localparam int OUT_W          = 18;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORDIC_W       = 33;
  localparam int PROJ_STAGES    = 5;
  localparam int QW             = AXIS_W + VEC_W + 2 + AXIS_W;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [OUT_W-1:0]    OUT_MAX     = 18'sd131071;
  localparam logic signed [OUT_W-1:0]    OUT_MIN     = -18'sd131072;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic [1:0]                 quad;
  } cordic_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int v0_w(int f);
    return imax(QW, 2 * f) + 2 - 2 * f;
  endfunction

  function automatic int v1_w(int f);
    return imax(v0_w(f), VEC_W) + 1;
  endfunction

  function automatic int x_w(int f);
    return AXIS_W + v1_w(f) + 1;
  endfunction

  function automatic int v2_w(int f);
    return x_w(f) + 1 - f;
  endfunction

  function automatic int cs_w(int f);
    return f + 2;
  endfunction

  // atan(2^-i), 2^32 units per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turns(int i);
    logic signed [CORDIC_W-1:0] r;
    case (i)
      0:  r = 33'sh020000000;
      1:  r = 33'sh012E4051D;
      2:  r = 33'sh009FB385B;
      3:  r = 33'sh0051111D4;
      4:  r = 33'sh0028B0D43;
      5:  r = 33'sh00145D7E1;
      6:  r = 33'sh000A2F61E;
      7:  r = 33'sh000517C55;
      8:  r = 33'sh00028BE53;
      9:  r = 33'sh000145F2E;
      10: r = 33'sh0000A2F98;
      11: r = 33'sh0000517CC;
      12: r = 33'sh000028BE6;
      13: r = 33'sh0000145F3;
      14: r = 33'sh000000A2F9;
      15: r = 33'sh00000517C;
      16: r = 33'sh0000028BE;
      17: r = 33'sh00000145F;
      18: r = 33'sh000000A2F;
      19: r = 33'sh000000517;
      20: r = 33'sh00000028B;
      21: r = 33'sh000000145;
      22: r = 33'sh0000000A2;
      23: r = 33'sh000000051;
      24: r = 33'sh000000028;
      25: r = 33'sh000000014;
      26: r = 33'sh00000000A;
      27: r = 33'sh000000005;
      28: r = 33'sh000000002;
      29: r = 33'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/aavr_cordic_cell.sv]
// One CORDIC rotation step, registered; cells chain into the sine/cosine pipe.
// Depends on aavr_pkg.
`default_nettype none
module aavr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  aavr_pkg::cordic_t d_in,
  output aavr_pkg::cordic_t d_out
);
  import aavr_pkg::*;

  cordic_t d_r, d_nxt;

  always_comb begin
    d_nxt.quad = d_in.quad;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - (d_in.y >>> IDX);
      d_nxt.y = d_in.y + (d_in.x >>> IDX);
      d_nxt.z = d_in.z - atan_turns(IDX);
    end else begin
      d_nxt.x = d_in.x + (d_in.y >>> IDX);
      d_nxt.y = d_in.y - (d_in.x >>> IDX);
      d_nxt.z = d_in.z + atan_turns(IDX);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

[hw/rtl/aavr_proj.sv]
// Projection pipe: dot product, axial part, perpendicular part, cross product.
// Five register stages. Depends on aavr_pkg.
`default_nettype none
module aavr_proj #(
  parameter int FRAC_BITS = aavr_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic signed [aavr_pkg::AXIS_W-1:0]               axis [3],
  input  logic signed [aavr_pkg::VEC_W-1:0]                vec  [3],
  output logic signed [aavr_pkg::v0_w(FRAC_BITS)-1:0]      v0   [3],
  output logic signed [aavr_pkg::v1_w(FRAC_BITS)-1:0]      v1   [3],
  output logic signed [aavr_pkg::v2_w(FRAC_BITS)-1:0]      v2   [3]
);
  import aavr_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PW  = AXIS_W + VEC_W;
  localparam int DW  = PW + 2;
  localparam int RW0 = imax(QW, 2 * F) + 2;
  localparam int V0W = v0_w(F);
  localparam int V1W = v1_w(F);
  localparam int XW  = x_w(F);
  localparam int V2W = v2_w(F);
  localparam logic signed [RW0-1:0] HALF0 = RW0'(1) << (2 * F - 1);
  localparam logic signed [XW:0]    HALF1 = (XW + 1)'(1) << (F - 1);

  logic signed [PW-1:0]     prod_r [3];
  logic signed [AXIS_W-1:0] a1_r [3], a2_r [3], a3_r [3], a4_r [3];
  logic signed [VEC_W-1:0]  vv1_r [3], vv2_r [3], vv3_r [3];
  logic signed [DW-1:0]     dot_r;
  logic signed [QW-1:0]     p_r [3];
  logic signed [V0W-1:0]    v0a_r [3], v0b_r [3];
  logic signed [V1W-1:0]    v1a_r [3], v1b_r [3];
  logic signed [V2W-1:0]    v2_r [3];
  logic signed [RW0-1:0]    rnd0 [3];
  logic signed [XW-1:0]     cr [3];
  logic signed [XW:0]       rnd1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd0[i] = RW0'(p_r[i]) + HALF0;
    end
    cr[0] = XW'(a4_r[1]) * XW'(v1a_r[2]) - XW'(a4_r[2]) * XW'(v1a_r[1]);
    cr[1] = XW'(a4_r[2]) * XW'(v1a_r[0]) - XW'(a4_r[0]) * XW'(v1a_r[2]);
    cr[2] = XW'(a4_r[0]) * XW'(v1a_r[1]) - XW'(a4_r[1]) * XW'(v1a_r[0]);
    for (int i = 0; i < 3; i++) begin
      rnd1[i] = (XW + 1)'(cr[i]) + HALF1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= PW'(vec[i]) * PW'(axis[i]);
      a1_r[i]   <= axis[i];
      vv1_r[i]  <= vec[i];
      a2_r[i]   <= a1_r[i];
      vv2_r[i]  <= vv1_r[i];
      p_r[i]    <= QW'(dot_r) * QW'(a2_r[i]);
      a3_r[i]   <= a2_r[i];
      vv3_r[i]  <= vv2_r[i];
      v0a_r[i]  <= V0W'(rnd0[i] >>> (2 * F));
      v1a_r[i]  <= V1W'(vv3_r[i]) - V1W'(V0W'(rnd0[i] >>> (2 * F)));
      a4_r[i]   <= a3_r[i];
      v0b_r[i]  <= v0a_r[i];
      v1b_r[i]  <= v1a_r[i];
      v2_r[i]   <= V2W'(rnd1[i] >>> F);
    end
    dot_r <= DW'(prod_r[0]) + DW'(prod_r[1]) + DW'(prod_r[2]);
  end

  assign v0 = v0b_r;
  assign v1 = v1b_r;
  assign v2 = v2_r;
endmodule
`default_nettype wire

[hw/rtl/aavr_mix.sv]
// Final combine: cos/sin weighting, rounding, axial add, saturation.
// Two register stages. Depends on aavr_pkg.
`default_nettype none
module aavr_mix #(
  parameter int FRAC_BITS = aavr_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic signed [aavr_pkg::cs_w(FRAC_BITS)-1:0] cs,
  input  logic signed [aavr_pkg::cs_w(FRAC_BITS)-1:0] sn,
  input  logic signed [aavr_pkg::v0_w(FRAC_BITS)-1:0] v0 [3],
  input  logic signed [aavr_pkg::v1_w(FRAC_BITS)-1:0] v1 [3],
  input  logic signed [aavr_pkg::v2_w(FRAC_BITS)-1:0] v2 [3],
  output logic signed [aavr_pkg::OUT_W-1:0]           res [3],
  output logic                                        clip
);
  import aavr_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int CW  = cs_w(F);
  localparam int V0W = v0_w(F);
  localparam int M1W = CW + v1_w(F);
  localparam int M2W = CW + v2_w(F);
  localparam int SW  = imax(M1W, M2W) + 1;
  localparam int RW  = SW + 1;
  localparam int TW  = imax(RW - F, V0W) + 1;
  localparam logic signed [RW-1:0] HALF = RW'(1) << (F - 1);

  logic signed [M1W-1:0]   m1_r [3];
  logic signed [M2W-1:0]   m2_r [3];
  logic signed [V0W-1:0]   v0_r [3];
  logic signed [RW-1:0]    sum [3];
  logic signed [TW-1:0]    tot [3];
  logic signed [OUT_W-1:0] res_nxt [3];
  logic [2:0]              hit;
  logic signed [OUT_W-1:0] res_r [3];
  logic                    clip_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = RW'(m1_r[i]) + RW'(m2_r[i]) + HALF;
      tot[i] = TW'(sum[i] >>> F) + TW'(v0_r[i]);
      if (tot[i] > TW'(OUT_MAX)) begin
        res_nxt[i] = OUT_MAX;
        hit[i]     = 1'b1;
      end else if (tot[i] < TW'(OUT_MIN)) begin
        res_nxt[i] = OUT_MIN;
        hit[i]     = 1'b1;
      end else begin
        res_nxt[i] = OUT_W'(tot[i]);
        hit[i]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_r[i]  <= M1W'(cs) * M1W'(v1[i]);
      m2_r[i]  <= M2W'(sn) * M2W'(v2[i]);
      v0_r[i]  <= v0[i];
      res_r[i] <= res_nxt[i];
    end
    clip_r <= |hit;
  end

  assign res  = res_r;
  assign clip = clip_r;
endmodule
`default_nettype wire

[hw/rtl/axis_angle_vector_rotation_core.sv]
// Axis-angle vector rotation core, top level.
// Depends on aavr_pkg, aavr_cordic_cell, aavr_proj, aavr_mix and the defines header.
//
// Usage:
//   Input channel: drive in_axis_*, in_vec_* and in_angle with start high; the
//   request is taken at any rising edge where start is high and busy is low.
//   busy is low whenever reset is released, so one request per cycle is taken.
//   Result channel: out_valid strobes for one cycle with out_x/y/z and
//   out_clipped. Results leave in request order and cannot be held off.
// Datapath: an input register, the 30-cell CORDIC row (one cell per step),
//   the sin/cos rounding register and the two-stage combine.
// Throughput: one request per cycle, sustained.
// Reset: synchronous, active low; clears the valid pipe, so requests in
//   flight are dropped and no strobe follows reset.
`default_nettype none
`include "axis_angle_vector_rotation_core_defines.svh"
module axis_angle_vector_rotation_core #(
  parameter int FRAC_BITS  = aavr_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = aavr_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [aavr_pkg::AXIS_W-1:0] in_axis_x,
  input  logic signed [aavr_pkg::AXIS_W-1:0] in_axis_y,
  input  logic signed [aavr_pkg::AXIS_W-1:0] in_axis_z,
  input  logic signed [aavr_pkg::VEC_W-1:0]  in_vec_x,
  input  logic signed [aavr_pkg::VEC_W-1:0]  in_vec_y,
  input  logic signed [aavr_pkg::VEC_W-1:0]  in_vec_z,
  input  logic [aavr_pkg::ANG_W-1:0]         in_angle,
  output logic                              out_valid,
  output logic signed [aavr_pkg::OUT_W-1:0]  out_x,
  output logic signed [aavr_pkg::OUT_W-1:0]  out_y,
  output logic signed [aavr_pkg::OUT_W-1:0]  out_z,
  output logic                              out_clipped
);
  import aavr_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int AB   = ANGLE_BITS;
  localparam int SH   = 30 - F;
  localparam int CW   = cs_w(F);
  localparam int V0W  = v0_w(F);
  localparam int V1W  = v1_w(F);
  localparam int V2W  = v2_w(F);
  localparam int DLY  = CORDIC_STEPS + 1 - PROJ_STAGES;
  localparam int PIPE = CORDIC_STEPS + 3;
  localparam logic signed [CORDIC_W:0] RND =
    (SH == 0) ? '0 : ((CORDIC_W + 1)'(1) << ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [CORDIC_W:0] ONE = (CORDIC_W + 1)'(1) << F;

  logic                     acc;
  logic [PIPE:0]            vld_r;
  logic signed [AXIS_W-1:0] axis_r [3];
  logic signed [VEC_W-1:0]  vec_r [3];
  logic [ANG_W-1:0]         ang_r;
  logic [31:0]              a32;
  cordic_t                  chain [0:CORDIC_STEPS];

  logic signed [CORDIC_W:0] xr, yr, xc, yc;
  logic signed [CW-1:0]     c_nxt, s_nxt, c_r, s_r;

  logic signed [V0W-1:0]    p_v0 [3];
  logic signed [V1W-1:0]    p_v1 [3];
  logic signed [V2W-1:0]    p_v2 [3];
  logic signed [V0W-1:0]    d0_r [DLY][3];
  logic signed [V1W-1:0]    d1_r [DLY][3];
  logic signed [V2W-1:0]    d2_r [DLY][3];
  logic signed [OUT_W-1:0]  res [3];
  logic                     rail_hit;
  logic signed [CORDIC_W:0] c_ext;

  assign busy = !rst_n;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE-1:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    axis_r[0] <= in_axis_x;
    axis_r[1] <= in_axis_y;
    axis_r[2] <= in_axis_z;
    vec_r[0]  <= in_vec_x;
    vec_r[1]  <= in_vec_y;
    vec_r[2]  <= in_vec_z;
    ang_r     <= in_angle;
  end

  // angle to a 32-bit turn, split into quadrant and first-quadrant residue
  always_comb begin
    a32 = (32'(ang_r) & ((32'd1 << AB) - 32'd1)) << (32 - AB);
    chain[0].quad = a32[31:30];
    chain[0].x    = CORDIC_GAIN;
    chain[0].y    = '0;
    chain[0].z    = CORDIC_W'({1'b0, a32[29:0]});
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    aavr_cordic_cell #(.IDX(g)) u_cell (
      .clk  (clk),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  always_comb begin
    xr = ((CORDIC_W + 1)'(chain[CORDIC_STEPS].x) + RND) >>> SH;
    yr = ((CORDIC_W + 1)'(chain[CORDIC_STEPS].y) + RND) >>> SH;
    xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
    case (chain[CORDIC_STEPS].quad)
      2'd0: begin
        c_nxt = CW'(xc);
        s_nxt = CW'(yc);
      end
      2'd1: begin
        c_nxt = -CW'(yc);
        s_nxt = CW'(xc);
      end
      2'd2: begin
        c_nxt = -CW'(xc);
        s_nxt = -CW'(yc);
      end
      default: begin
        c_nxt = CW'(yc);
        s_nxt = -CW'(xc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    s_r <= s_nxt;
  end

  aavr_proj #(.FRAC_BITS(F)) u_proj (
    .clk (clk),
    .axis(axis_r),
    .vec (vec_r),
    .v0  (p_v0),
    .v1  (p_v1),
    .v2  (p_v2)
  );

  // align projection results with the sin/cos register
  always_ff @(posedge clk) begin
    d0_r[0] <= p_v0;
    d1_r[0] <= p_v1;
    d2_r[0] <= p_v2;
    for (int k = 1; k < DLY; k++) begin
      d0_r[k] <= d0_r[k-1];
      d1_r[k] <= d1_r[k-1];
      d2_r[k] <= d2_r[k-1];
    end
  end

  aavr_mix #(.FRAC_BITS(F)) u_mix (
    .clk (clk),
    .cs  (c_r),
    .sn  (s_r),
    .v0  (d0_r[DLY-1]),
    .v1  (d1_r[DLY-1]),
    .v2  (d2_r[DLY-1]),
    .res (res),
    .clip(out_clipped)
  );

  assign out_valid = vld_r[PIPE];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];

  assign rail_hit = (out_x == OUT_MAX) || (out_x == OUT_MIN) ||
                    (out_y == OUT_MAX) || (out_y == OUT_MIN) ||
                    (out_z == OUT_MAX) || (out_z == OUT_MIN);
  assign c_ext    = (CORDIC_W + 1)'(c_r);

  `AAVR_ASSERT(a_strobe_has_request, out_valid |-> $past(acc, PIPE + 1), "strobe without request")
  `AAVR_ASSERT(a_clip_at_rail, out_valid && out_clipped |-> rail_hit, "clip flag off rail")
  `AAVR_ASSERT(a_trig_clamped, vld_r[CORDIC_STEPS + 1] |-> c_ext <= ONE && c_ext >= -ONE, "cos range")
  `AAVR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "strobe after reset")
endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for axis_angle_vector_rotation_core: random and directed rotation requests,
// results predicted by a fixed-point Rodrigues model with a bit-exact CORDIC.
// Depends on aavr_pkg and the core RTL.
`default_nettype none
module tb_top;
  import aavr_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;
  localparam int LATENCY = 34;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    clipped;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [AXIS_W-1:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic signed [VEC_W-1:0]  in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic [ANG_W-1:0]         in_angle = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_x, out_y, out_z;
  logic out_clipped;
  int errors = 0;

  always #5 clk = ~clk;

  axis_angle_vector_rotation_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_angle(in_angle), .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_clipped(out_clipped)
  );

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    if (n == 0) return v;
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_one(longint v);
    longint one;
    one = 64'sd1 <<< FB;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic void trig(input logic [ANG_W-1:0] ang, output longint c_o,
                               output longint s_o);
    logic [31:0] a32;
    longint x, y, z, dx, dy, c, s, step;
    a32 = 32'(ang) << (32 - AB);
    x = 652032874; y = 0; z = longint'(a32[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      step = longint'(atan_turns(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= step;
      end else begin
        x += dx; y -= dy; z += step;
      end
    end
    c = clamp_one(round_shift(x, 30 - FB));
    s = clamp_one(round_shift(y, 30 - FB));
    case (a32[31:30])
      2'd0: begin c_o = c; s_o = s; end
      2'd1: begin c_o = -s; s_o = c; end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endfunction

  function automatic rot_result_t rotate(longint a[3], longint v[3],
                                         logic [ANG_W-1:0] ang);
    rot_result_t r;
    longint c, s, dot, v0[3], v1[3], v2[3], o[3];
    r.clipped = 1'b0;
    trig(ang, c, s);
    dot = v[0] * a[0] + v[1] * a[1] + v[2] * a[2];
    for (int i = 0; i < 3; i++) begin
      v0[i] = round_shift(dot * a[i], 2 * FB);
      v1[i] = v[i] - v0[i];
    end
    v2[0] = round_shift(a[1] * v1[2] - a[2] * v1[1], FB);
    v2[1] = round_shift(a[2] * v1[0] - a[0] * v1[2], FB);
    v2[2] = round_shift(a[0] * v1[1] - a[1] * v1[0], FB);
    for (int i = 0; i < 3; i++) begin
      o[i] = v0[i] + round_shift(c * v1[i] + s * v2[i], FB);
      if (o[i] > 131071) begin o[i] = 131071; r.clipped = 1'b1; end
      if (o[i] < -131072) begin o[i] = -131072; r.clipped = 1'b1; end
    end
    r.x = OUT_W'(o[0]); r.y = OUT_W'(o[1]); r.z = OUT_W'(o[2]);
    return r;
  endfunction

  class rotation_scoreboard;
    rot_result_t pending[$];

    function void note_request(longint a[3], longint v[3], logic [ANG_W-1:0] ang);
      pending.push_back(rotate(a, v, ang));
    endfunction

    task check_result(rot_result_t got);
      rot_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report("out_x", got.x, want.x);
      if (got.y !== want.y) report("out_y", got.y, want.y);
      if (got.z !== want.z) report("out_z", got.z, want.z);
      if (got.clipped !== want.clipped) report("out_clipped", got.clipped, want.clipped);
    endtask
  endclass

  rotation_scoreboard sb = new();

  always @(posedge clk) begin
    rot_result_t got;
    longint a[3], v[3];
    if (rst_n && start && !busy) begin
      a[0] = in_axis_x; a[1] = in_axis_y; a[2] = in_axis_z;
      v[0] = in_vec_x; v[1] = in_vec_y; v[2] = in_vec_z;
      sb.note_request(a, v, in_angle);
    end
    if (rst_n && out_valid) begin
      got.x = out_x; got.y = out_y; got.z = out_z; got.clipped = out_clipped;
      sb.check_result(got);
    end
  end

  // holds start until the request is taken; caller lowers it when done
  task automatic send(input int ax, ay, az, vx, vy, vz, ang);
    in_axis_x <= AXIS_W'(ax); in_axis_y <= AXIS_W'(ay); in_axis_z <= AXIS_W'(az);
    in_vec_x <= VEC_W'(vx); in_vec_y <= VEC_W'(vy); in_vec_z <= VEC_W'(vz);
    in_angle <= ANG_W'(ang);
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int rand_axis();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return $urandom_range(0, 32768) - 16384;
    if (k < 8) return (k == 6) ? 16384 : -16384;
    return $signed(16'($urandom()));
  endfunction

  function automatic int rand_vec();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 131071 : -131072;
    return $signed(18'($urandom()));
  endfunction

  task automatic random_request();
    int ax, ay, az, c;
    c = $urandom_range(0, 3);
    // half unit axes along a coordinate direction or a diagonal, half arbitrary
    if (c == 0) begin
      ax = 0; ay = 0; az = 0;
      case ($urandom_range(0, 2))
        0: ax = $urandom_range(0, 1) ? 16384 : -16384;
        1: ay = $urandom_range(0, 1) ? 16384 : -16384;
        default: az = $urandom_range(0, 1) ? 16384 : -16384;
      endcase
    end else if (c == 1) begin
      ax = $urandom_range(0, 1) ? 9459 : -9459;
      ay = $urandom_range(0, 1) ? 9459 : -9459;
      az = $urandom_range(0, 1) ? 9459 : -9459;
    end else begin
      ax = rand_axis(); ay = rand_axis(); az = rand_axis();
    end
    send(ax, ay, az, rand_vec(), rand_vec(), rand_vec(), $urandom_range(0, 65535));
  endtask

  initial begin
    int burst;
    bit drained;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(16384, 0, 0, 16384, 16384, 0, 16384);
    send(0, 16384, 0, 16384, 0, 16384, 32768);
    send(0, 0, 16384, 131071, -131072, 131071, 49152);
    send(0, 0, 16384, 16384, 0, 0, 0);
    send(0, 0, 16384, 16384, 0, 0, 65535);
    send(0, 0, 16384, 16384, 0, 0, 8192);
    send(-16384, -16384, -16384, 131071, 131071, 131071, 12345);
    send(16384, 16384, 16384, -131072, -131072, -131072, 40000);
    send(-32768, 32767, -32768, 131071, -131072, 131071, 32767);
    send(0, 0, 0, 131071, -131072, 5, 20000);
    send(9459, 9459, 9459, -1, 1, -131072, 21845);
    send(-16384, 0, 16384, 131071, 131071, -131072, 16383);
    send(-1, 1, -1, -1, -1, -1, 1);
    idle(3);
    for (int n = 0; n < 1300; ) begin
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 1300; b++, n++) random_request();
      if (n > 600 && !drained) begin
        drained = 1'b1;
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 40));
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
